// ===== hdl/nns_pkg.sv =====
// -----------------------------------------------------------------------------
// nns_pkg
// Types, constants and helpers shared by the nearest-neighbour scaler.
// -----------------------------------------------------------------------------
package nns_pkg;

    localparam int DIM_W         = 13;
    localparam int IDX_W         = 12;
    localparam int PIX_W         = 16;
    localparam int REM_W         = 14;
    localparam int NUM_W         = 26;
    localparam int DIV_STEPS     = 26;
    localparam int DIV_CNT_W     = 5;
    localparam int DIM_LIMIT     = 4096;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int QUEUE_DEPTH   = 4;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_SRC_WIDTH  = 2'd0;
    localparam t_reg_idx REG_SRC_HEIGHT = 2'd1;
    localparam t_reg_idx REG_DST_WIDTH  = 2'd2;
    localparam t_reg_idx REG_DST_HEIGHT = 2'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    typedef struct packed {
        logic              kind;
        logic signed [15:0] pixel_in;
    } t_in;

    typedef struct packed {
        logic signed [15:0] pixel_out;
        logic [11:0]        out_col;
        logic [11:0]        out_row;
        logic               row_end;
        logic               image_end;
        logic               need_row;
        logic [11:0]        next_src_row;
    } t_out;

    typedef struct packed {
        logic               pull;
        logic [11:0]        col;
        logic signed [15:0] pixel;
        logic [11:0]        out_col;
        logic [11:0]        out_row;
        logic               row_end;
        logic               image_end;
        logic               need_row;
        logic [11:0]        next_src_row;
    } t_cmd;

    typedef struct packed {
        logic [12:0] src_width;
        logic [12:0] src_height;
        logic [12:0] dst_width;
        logic [12:0] dst_height;
    } t_cfg;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_PREP,
        SEQ_MUL,
        SEQ_START,
        SEQ_WAIT
    } t_seq;

    typedef enum logic [2:0] {
        JOB_COL_STEP,
        JOB_COL_ZERO,
        JOB_COL_POS,
        JOB_ROW_STEP,
        JOB_ROW_ZERO,
        JOB_ROW_POS
    } t_job;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v, input logic [12:0] hi);
        logic [12:0] res;
        if (v == 13'd0) begin
            res = 13'd1;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== hdl/nns_div.sv =====
// -----------------------------------------------------------------------------
// nns_div
// Restoring divider, one quotient bit per cycle, for the ratio set-up.
// -----------------------------------------------------------------------------
module nns_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [25:0] i_dividend,
    input  logic [13:0] i_divisor,
    output logic        o_done,
    output logic [25:0] o_quotient,
    output logic [13:0] o_remainder
);

    logic [25:0] r_quo;
    logic [13:0] r_rem;
    logic [13:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [14:0] trial;
    logic        ge;
    logic [14:0] diff;

    assign trial = {r_rem, r_quo[25]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= nns_pkg::DIV_CNT_W'(nns_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[13:0] : trial[13:0];
            r_quo <= {r_quo[24:0], ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== hdl/nns_front.sv =====
// -----------------------------------------------------------------------------
// nns_front
// Accepts items, steps the column/row mapping counters and issues commands.
// -----------------------------------------------------------------------------
module nns_front #(
    parameter int WIDTH_LIM = nns_pkg::MAX_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nns_pkg::t_cfg  i_cfg,
    input  logic           i_cfg_we,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nns_pkg::t_in   i_in_data,
    input  logic           i_q_full,
    output logic           o_push,
    output nns_pkg::t_cmd  o_cmd
);

    nns_pkg::t_seq r_seq, n_seq;
    nns_pkg::t_job r_job, n_job;

    logic [12:0] r_sw, r_sh, r_dw, r_dh;
    logic [11:0] r_load_col, r_x, r_y;
    logic [11:0] r_cq, r_rq, r_c0q, r_r0q;
    logic [13:0] r_cr, r_rr, r_c0r, r_r0r, r_csr, r_rsr;
    logic [12:0] r_csq, r_rsq;
    logic [25:0] r_cprod, r_rprod;

    logic        div_start;
    logic        div_done;
    logic [25:0] div_q;
    logic [13:0] div_r;
    logic [25:0] div_num;
    logic [13:0] div_den;

    logic [12:0] wlim, dw_m1, dh_m1;
    logic [13:0] dw2, dh2;
    logic [11:0] x_cl, y_cl;
    logic [25:0] col_prod, row_prod;

    logic        accept, is_pull, row_end, img_end, need;
    logic [14:0] c_sum, r_sum;
    logic        c_wrap, r_wrap;
    logic [13:0] n_cr, n_rr;
    logic [12:0] c_qs, r_qs;
    logic [11:0] n_cq, n_rq, next_src;
    logic [11:0] ld_col;
    logic [12:0] ld_nxt;
    logic [11:0] n_load_col;

    assign wlim  = 13'(WIDTH_LIM);
    assign dw_m1 = r_dw - 13'd1;
    assign dh_m1 = r_dh - 13'd1;
    assign dw2   = {r_dw, 1'b0};
    assign dh2   = {r_dh, 1'b0};
    assign x_cl  = ({1'b0, r_x} >= r_dw) ? dw_m1[11:0] : r_x;
    assign y_cl  = ({1'b0, r_y} >= r_dh) ? dh_m1[11:0] : r_y;
    assign col_prod = {x_cl, 1'b1} * r_sw;
    assign row_prod = {y_cl, 1'b1} * r_sh;

    assign o_in_ready = (r_seq == nns_pkg::SEQ_IDLE) && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_pull    = i_in_data.kind == nns_pkg::KIND_PULL;
    assign o_push     = accept;

    assign row_end = ({1'b0, x_cl} == dw_m1);
    assign img_end = row_end && ({1'b0, y_cl} == dh_m1);

    assign c_sum  = {1'b0, r_cr} + {1'b0, r_csr};
    assign c_wrap = c_sum >= {1'b0, dw2};
    assign n_cr   = c_wrap ? 14'(c_sum - {1'b0, dw2}) : c_sum[13:0];
    assign c_qs   = {1'b0, r_cq} + r_csq + 13'(c_wrap);
    assign n_cq   = c_qs[11:0];

    assign r_sum  = {1'b0, r_rr} + {1'b0, r_rsr};
    assign r_wrap = r_sum >= {1'b0, dh2};
    assign n_rr   = r_wrap ? 14'(r_sum - {1'b0, dh2}) : r_sum[13:0];
    assign r_qs   = {1'b0, r_rq} + r_rsq + 13'(r_wrap);
    assign n_rq   = r_qs[11:0];

    assign need     = img_end || (row_end && (n_rq != r_rq));
    assign next_src = !row_end ? r_rq : (img_end ? r_r0q : n_rq);

    assign ld_col     = ({1'b0, r_load_col} >= r_sw) ? 12'd0 : r_load_col;
    assign ld_nxt     = {1'b0, ld_col} + 13'd1;
    assign n_load_col = (ld_nxt == r_sw) ? 12'd0 : ld_nxt[11:0];

    always_comb begin
        o_cmd.pull         = is_pull;
        o_cmd.col          = is_pull ? r_cq : ld_col;
        o_cmd.pixel        = i_in_data.pixel_in;
        o_cmd.out_col      = x_cl;
        o_cmd.out_row      = y_cl;
        o_cmd.row_end      = row_end;
        o_cmd.image_end    = img_end;
        o_cmd.need_row     = need;
        o_cmd.next_src_row = next_src;
    end

    always_comb begin
        unique case (r_job)
            nns_pkg::JOB_COL_STEP: begin
                div_num = {12'd0, r_sw, 1'b0};
                div_den = dw2;
                n_job   = nns_pkg::JOB_COL_ZERO;
            end
            nns_pkg::JOB_COL_ZERO: begin
                div_num = {13'd0, r_sw};
                div_den = dw2;
                n_job   = nns_pkg::JOB_COL_POS;
            end
            nns_pkg::JOB_COL_POS: begin
                div_num = r_cprod;
                div_den = dw2;
                n_job   = nns_pkg::JOB_ROW_STEP;
            end
            nns_pkg::JOB_ROW_STEP: begin
                div_num = {12'd0, r_sh, 1'b0};
                div_den = dh2;
                n_job   = nns_pkg::JOB_ROW_ZERO;
            end
            nns_pkg::JOB_ROW_ZERO: begin
                div_num = {13'd0, r_sh};
                div_den = dh2;
                n_job   = nns_pkg::JOB_ROW_POS;
            end
            default: begin
                div_num = r_rprod;
                div_den = dh2;
                n_job   = nns_pkg::JOB_COL_STEP;
            end
        endcase
    end

    always_comb begin
        n_seq     = r_seq;
        div_start = 1'b0;
        priority if (i_cfg_we) begin
            n_seq = nns_pkg::SEQ_PREP;
        end else begin
            unique case (r_seq)
                nns_pkg::SEQ_IDLE:  n_seq = nns_pkg::SEQ_IDLE;
                nns_pkg::SEQ_PREP:  n_seq = nns_pkg::SEQ_MUL;
                nns_pkg::SEQ_MUL:   n_seq = nns_pkg::SEQ_START;
                nns_pkg::SEQ_START: begin
                    div_start = 1'b1;
                    n_seq     = nns_pkg::SEQ_WAIT;
                end
                nns_pkg::SEQ_WAIT: begin
                    if (div_done) begin
                        n_seq = (r_job == nns_pkg::JOB_ROW_POS) ? nns_pkg::SEQ_IDLE
                                                                : nns_pkg::SEQ_START;
                    end
                end
                default: n_seq = nns_pkg::SEQ_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= nns_pkg::SEQ_IDLE;
        end else begin
            r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_seq == nns_pkg::SEQ_MUL) begin
            r_cprod <= col_prod;
            r_rprod <= row_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job      <= nns_pkg::JOB_COL_STEP;
            r_sw       <= 13'd1;
            r_sh       <= 13'd1;
            r_dw       <= 13'd1;
            r_dh       <= 13'd1;
            r_load_col <= '0;
            r_x        <= '0;
            r_y        <= '0;
            r_cq       <= '0;
            r_cr       <= 14'd1;
            r_rq       <= '0;
            r_rr       <= 14'd1;
            r_c0q      <= '0;
            r_c0r      <= 14'd1;
            r_r0q      <= '0;
            r_r0r      <= 14'd1;
            r_csq      <= 13'd1;
            r_csr      <= '0;
            r_rsq      <= 13'd1;
            r_rsr      <= '0;
        end else if (r_seq == nns_pkg::SEQ_PREP) begin
            r_job <= nns_pkg::JOB_COL_STEP;
            r_sw  <= nns_pkg::clamp_dim(i_cfg.src_width, wlim);
            r_sh  <= nns_pkg::clamp_dim(i_cfg.src_height, 13'(nns_pkg::DIM_LIMIT));
            r_dw  <= nns_pkg::clamp_dim(i_cfg.dst_width, wlim);
            r_dh  <= nns_pkg::clamp_dim(i_cfg.dst_height, 13'(nns_pkg::DIM_LIMIT));
        end else if (r_seq == nns_pkg::SEQ_WAIT) begin
            if (div_done) begin
                r_job <= n_job;
                unique case (r_job)
                    nns_pkg::JOB_COL_STEP: begin
                        r_csq <= div_q[12:0];
                        r_csr <= div_r;
                    end
                    nns_pkg::JOB_COL_ZERO: begin
                        r_c0q <= div_q[11:0];
                        r_c0r <= div_r;
                    end
                    nns_pkg::JOB_COL_POS: begin
                        r_cq <= div_q[11:0];
                        r_cr <= div_r;
                    end
                    nns_pkg::JOB_ROW_STEP: begin
                        r_rsq <= div_q[12:0];
                        r_rsr <= div_r;
                    end
                    nns_pkg::JOB_ROW_ZERO: begin
                        r_r0q <= div_q[11:0];
                        r_r0r <= div_r;
                    end
                    default: begin
                        r_rq <= div_q[11:0];
                        r_rr <= div_r;
                    end
                endcase
            end
        end else if (accept) begin
            if (!is_pull) begin
                r_load_col <= n_load_col;
            end else if (!row_end) begin
                r_x  <= x_cl + 12'd1;
                r_y  <= y_cl;
                r_cq <= n_cq;
                r_cr <= n_cr;
            end else begin
                r_x  <= '0;
                r_cq <= r_c0q;
                r_cr <= r_c0r;
                if (img_end) begin
                    r_y  <= '0;
                    r_rq <= r_r0q;
                    r_rr <= r_r0r;
                end else begin
                    r_y  <= y_cl + 12'd1;
                    r_rq <= n_rq;
                    r_rr <= n_rr;
                end
            end
        end
    end

    nns_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_num),
        .i_divisor   (div_den),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    a_idle_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == nns_pkg::SEQ_IDLE) |-> ({1'b0, r_cq} < r_sw) && ({1'b0, r_rq} < r_sh))
        else $error("mapped source index outside the source size");

    a_idle_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == nns_pkg::SEQ_IDLE) |-> (r_cr < dw2) && (r_rr < dh2))
        else $error("mapping remainder not reduced");

endmodule

// ===== hdl/nns_fifo.sv =====
// -----------------------------------------------------------------------------
// nns_fifo
// Short command queue between the front and the back end.
// -----------------------------------------------------------------------------
module nns_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nns_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output nns_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    localparam int DEPTH = nns_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    nns_pkg::t_cmd r_slot [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic [PW-1:0] wp_nxt, rp_nxt;

    assign wp_nxt  = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign rp_nxt  = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign o_full  = (r_cnt == (PW + 1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= wp_nxt;
            end
            if (i_pop) begin
                r_rp <= rp_nxt;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty command queue");

endmodule

// ===== hdl/nns_back.sv =====
// -----------------------------------------------------------------------------
// nns_back
// Line store, read stage and output register; executes queued commands.
// -----------------------------------------------------------------------------
module nns_back #(
    parameter int DEPTH = nns_pkg::MAX_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  nns_pkg::t_cmd i_q_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output nns_pkg::t_out o_out_data
);

    localparam int AW = $clog2(DEPTH);

    logic signed [15:0] r_store [DEPTH];
    logic signed [15:0] r_rd;
    nns_pkg::t_cmd      r_a_cmd;
    logic               r_a_valid;
    nns_pkg::t_out      r_o_data;
    logic               r_o_valid;
    logic               a_adv, a_free, wr_en, rd_en;

    assign a_adv  = !r_o_valid || i_out_ready;
    assign a_free = !r_a_valid || a_adv;
    assign o_pop  = i_q_valid && (!i_q_cmd.pull || a_free);
    assign wr_en  = o_pop && !i_q_cmd.pull;
    assign rd_en  = o_pop && i_q_cmd.pull;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[i_q_cmd.col[AW-1:0]] <= i_q_cmd.pixel;
        end
        if (rd_en) begin
            r_rd <= r_store[i_q_cmd.col[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_a_cmd <= i_q_cmd;
        end
        if (a_adv && r_a_valid) begin
            r_o_data.pixel_out    <= r_rd;
            r_o_data.out_col      <= r_a_cmd.out_col;
            r_o_data.out_row      <= r_a_cmd.out_row;
            r_o_data.row_end      <= r_a_cmd.row_end;
            r_o_data.image_end    <= r_a_cmd.image_end;
            r_o_data.need_row     <= r_a_cmd.need_row;
            r_o_data.next_src_row <= r_a_cmd.next_src_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (rd_en) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    a_read_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_o_valid && !i_out_ready) |=> r_a_valid)
        else $error("read stage dropped a transaction while stalled");

endmodule

// ===== hdl/nearest_neighbor_image_scaler_core.sv =====
// -----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_core
// Nearest-neighbour image scaler with a one-row line store.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in_data): a load transaction writes
//   one source pixel into the line store at the next load column; a pull
//   transaction produces the next output pixel in raster order.
//   Output channel (o_out_valid/i_out_ready/o_out_data): one transaction per
//   pull, none per load, in order.
//   Throughput is one transaction per cycle on both channels unless a ratio
//   set-up runs or the receiver stalls. A pull result passes through the
//   command queue, the registered line-store read and the output register.
//   Registers (APB, 4*i byte addresses): src_width, src_height, dst_width,
//   dst_height. A write starts a ratio set-up of six serial divisions during
//   which o_in_ready is low.
//   Reset clears all counters and sets every size to 1; the line store holds
//   no defined data until loaded. When the receiver stalls, results wait in
//   the output register, the read stage and the four-entry queue, after
//   which o_in_ready drops.
// -----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_core #(
    parameter int MAX_WIDTH = nns_pkg::MAX_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  nns_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output nns_pkg::t_out o_out_data
);

    localparam int WIDTH_LIM = (MAX_WIDTH < nns_pkg::DIM_LIMIT) ? MAX_WIDTH
                                                                : nns_pkg::DIM_LIMIT;

    nns_pkg::t_cfg    r_cfg;
    logic             cfg_we;
    nns_pkg::t_reg_idx reg_idx;
    logic             q_full, q_valid, q_pop, push;
    nns_pkg::t_cmd    push_cmd, q_cmd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= 13'd1;
            r_cfg.src_height <= 13'd1;
            r_cfg.dst_width  <= 13'd1;
            r_cfg.dst_height <= 13'd1;
        end else if (cfg_we) begin
            unique case (reg_idx)
                nns_pkg::REG_SRC_WIDTH:  r_cfg.src_width  <= pwdata[12:0];
                nns_pkg::REG_SRC_HEIGHT: r_cfg.src_height <= pwdata[12:0];
                nns_pkg::REG_DST_WIDTH:  r_cfg.dst_width  <= pwdata[12:0];
                nns_pkg::REG_DST_HEIGHT: r_cfg.dst_height <= pwdata[12:0];
                default:                 r_cfg            <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            nns_pkg::REG_SRC_WIDTH:  prdata = {19'd0, r_cfg.src_width};
            nns_pkg::REG_SRC_HEIGHT: prdata = {19'd0, r_cfg.src_height};
            nns_pkg::REG_DST_WIDTH:  prdata = {19'd0, r_cfg.dst_width};
            nns_pkg::REG_DST_HEIGHT: prdata = {19'd0, r_cfg.dst_height};
            default:                 prdata = '0;
        endcase
    end

    nns_front #(
        .WIDTH_LIM (WIDTH_LIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cfg_we   (cfg_we),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    nns_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    nns_back #(
        .DEPTH (WIDTH_LIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest-neighbour image scaler core. A directed
// table covers the pixel extremes after reset and then small up- and
// down-scaling settings. Random phases follow: source rows up to 64 wide and
// output rows up to 64 pulls with random content, random noise items, and size
// registers written over the APB port between phases. Every pull result is
// checked against the table or an in-bench scaler model of accepted items.
// -----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 16;
    localparam int STORE_DEPTH  = 4096;
    localparam int HOLD_CYCLES  = 600;
    localparam int RAND_ITEMS   = 900;

    typedef enum logic {STEP_ITEM, STEP_DIMS} t_step_op;

    typedef struct {
        t_step_op      op;
        logic [12:0]   d0;
        logic [12:0]   d1;
        logic [12:0]   d2;
        logic [12:0]   d3;
        nns_pkg::t_in  item;
        bit            has_exp;
        nns_pkg::t_out exp;
    } t_dir_step;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [3:0]    paddr   = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          in_valid  = 1'b0;
    logic          o_in_ready;
    nns_pkg::t_in  in_data   = '0;
    logic          o_out_valid;
    logic          out_ready = 1'b0;
    nns_pkg::t_out o_out_data;

    logic [12:0]        dim_reg [4];
    logic signed [15:0] pixel_store [STORE_DEPTH];
    bit                 pixel_loaded [STORE_DEPTH];
    int unsigned        load_col_q;
    int unsigned        out_col_q;
    int unsigned        out_row_q;

    nns_pkg::t_out expected_pixels [$];
    t_dir_step     dir_steps [$];
    int unsigned   err_count   = 0;
    int unsigned   cycle_count = 0;
    int unsigned   gen_count   = 0;
    bit            calm        = 1'b0;
    int unsigned   hold_req    = 0;
    int unsigned   hold_seen   = 0;
    int unsigned   hold_left   = 0;
    nns_pkg::t_out want_pixel;

    nearest_neighbor_image_scaler_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int unsigned eff_dim(input int idx);
        int unsigned v;
        v = dim_reg[idx];
        if (v == 0) begin
            v = 1;
        end else if (v > nns_pkg::DIM_LIMIT) begin
            v = nns_pkg::DIM_LIMIT;
        end
        return v;
    endfunction

    function automatic int unsigned map_coord(input int unsigned pos, input int unsigned src,
                                              input int unsigned dst);
        return ((2 * pos + 1) * src) / (2 * dst);
    endfunction

    function automatic int unsigned cur_x();
        int unsigned dw;
        dw = eff_dim(nns_pkg::REG_DST_WIDTH);
        return (out_col_q < dw) ? out_col_q : dw - 1;
    endfunction

    function automatic bit pull_safe();
        return pixel_loaded[map_coord(cur_x(), eff_dim(nns_pkg::REG_SRC_WIDTH),
                                      eff_dim(nns_pkg::REG_DST_WIDTH))];
    endfunction

    // advance the scaler state by one transaction; return 1 with a result for a pull
    function automatic bit scale_step(input nns_pkg::t_in it, output nns_pkg::t_out res);
        int unsigned sw, sh, dw, dh, c, x, y, ay, nxt;
        bit          re, ie, need;
        sw  = eff_dim(nns_pkg::REG_SRC_WIDTH);
        sh  = eff_dim(nns_pkg::REG_SRC_HEIGHT);
        dw  = eff_dim(nns_pkg::REG_DST_WIDTH);
        dh  = eff_dim(nns_pkg::REG_DST_HEIGHT);
        res = '0;
        if (it.kind == nns_pkg::KIND_LOAD) begin
            c = (load_col_q < sw) ? load_col_q : 0;
            pixel_store[c]  = it.pixel_in;
            pixel_loaded[c] = 1'b1;
            c++;
            load_col_q = (c >= sw) ? 0 : c;
            return 1'b0;
        end
        x  = cur_x();
        y  = (out_row_q < dh) ? out_row_q : dh - 1;
        ay = map_coord(y, sh, dh);
        re = (x == dw - 1);
        ie = re && (y == dh - 1);
        if (!re) begin
            nxt  = ay;
            need = 1'b0;
        end else begin
            nxt  = map_coord(ie ? 0 : y + 1, sh, dh);
            need = ie || (nxt != ay);
        end
        res.pixel_out    = pixel_store[map_coord(x, sw, dw)];
        res.out_col      = 12'(x);
        res.out_row      = 12'(y);
        res.row_end      = re;
        res.image_end    = ie;
        res.need_row     = need;
        res.next_src_row = 12'(nxt);
        if (re) begin
            out_col_q = 0;
            out_row_q = ie ? 0 : y + 1;
        end else begin
            out_col_q = x + 1;
            out_row_q = y;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic compare_pixel(input nns_pkg::t_out got, input nns_pkg::t_out want);
        if (got.pixel_out !== want.pixel_out)
            report_mismatch($sformatf("pixel_out %h exp %h", got.pixel_out, want.pixel_out));
        if (got.out_col !== want.out_col)
            report_mismatch($sformatf("out_col %0d exp %0d", got.out_col, want.out_col));
        if (got.out_row !== want.out_row)
            report_mismatch($sformatf("out_row %0d exp %0d", got.out_row, want.out_row));
        if (got.row_end !== want.row_end)
            report_mismatch($sformatf("row_end %b exp %b", got.row_end, want.row_end));
        if (got.image_end !== want.image_end)
            report_mismatch($sformatf("image_end %b exp %b", got.image_end, want.image_end));
        if (got.need_row !== want.need_row)
            report_mismatch($sformatf("need_row %b exp %b", got.need_row, want.need_row));
        if (got.next_src_row !== want.next_src_row)
            report_mismatch($sformatf("next_src_row %0d exp %0d", got.next_src_row,
                                      want.next_src_row));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result transaction with none expected");
            end else begin
                want_pixel = expected_pixels.pop_front();
                compare_pixel(o_out_data, want_pixel);
            end
        end
    end

    // receiver: random stalls, a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    task automatic apb_write(input int idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input int idx, output logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 4'(idx * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        val = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [12:0] a, input logic [12:0] b, input logic [12:0] c,
                            input logic [12:0] d);
        logic [12:0] vals [4];
        logic [31:0] rd;
        vals[0] = a;
        vals[1] = b;
        vals[2] = c;
        vals[3] = d;
        wait_idle();
        for (int i = 0; i < 4; i++) begin
            apb_write(i, {19'($urandom), vals[i]});
            dim_reg[i] = vals[i];
        end
        for (int i = 0; i < 4; i++) begin
            apb_read(i, rd);
            if (rd !== {19'd0, dim_reg[i]})
                report_mismatch($sformatf("register %0d reads %h exp %h", i, rd, dim_reg[i]));
        end
    endtask

    task automatic send_item(input nns_pkg::t_in it, input bit has_exp,
                             input nns_pkg::t_out exp);
        nns_pkg::t_out pred;
        while (!calm && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        if (scale_step(it, pred))
            expected_pixels.push_back(has_exp ? exp : pred);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_gen(input logic kind);
        nns_pkg::t_in  it;
        nns_pkg::t_out none;
        it.kind     = kind;
        it.pixel_in = 16'($urandom);
        if (it.kind == nns_pkg::KIND_PULL && !pull_safe())
            it.kind = nns_pkg::KIND_LOAD;
        none = '0;
        send_item(it, 1'b0, none);
        gen_count++;
    endtask

    // load a source row when sw <= 64, then pull up to 64 times toward the row end
    task automatic run_row();
        int unsigned sw, n;
        sw = eff_dim(nns_pkg::REG_SRC_WIDTH);
        n  = eff_dim(nns_pkg::REG_DST_WIDTH) - cur_x();
        if (sw <= 64)
            repeat (sw) send_gen(nns_pkg::KIND_LOAD);
        if (n > 64)
            n = 64;
        repeat (n) send_gen(nns_pkg::KIND_PULL);
    endtask

    function automatic logic [12:0] rand_width();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            return 13'd0;
        if (r < 7)
            return 13'($urandom_range(9, 64));
        if (r < 10)
            return 13'($urandom_range(4096, 8191));
        return 13'($urandom_range(1, 8));
    endfunction

    function automatic logic [12:0] rand_height();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return 13'd0;
        if (r < 15)
            return 13'($urandom_range(9, 300));
        if (r < 20)
            return 13'($urandom_range(4096, 8191));
        return 13'($urandom_range(1, 8));
    endfunction

    function automatic nns_pkg::t_out last_pixel(input logic [15:0] pix);
        nns_pkg::t_out r;
        r.pixel_out    = pix;
        r.out_col      = '0;
        r.out_row      = '0;
        r.row_end      = 1'b1;
        r.image_end    = 1'b1;
        r.need_row     = 1'b1;
        r.next_src_row = '0;
        return r;
    endfunction

    function automatic void dir_item(input logic kind, input logic [15:0] pix, input bit has_exp,
                                     input nns_pkg::t_out exp);
        t_dir_step s;
        s.op            = STEP_ITEM;
        s.d0            = '0;
        s.d1            = '0;
        s.d2            = '0;
        s.d3            = '0;
        s.item.kind     = kind;
        s.item.pixel_in = pix;
        s.has_exp       = has_exp;
        s.exp           = exp;
        dir_steps.push_back(s);
    endfunction

    function automatic void dir_dims(input logic [12:0] a, input logic [12:0] b,
                                     input logic [12:0] c, input logic [12:0] d);
        t_dir_step s;
        s.op      = STEP_DIMS;
        s.d0      = a;
        s.d1      = b;
        s.d2      = c;
        s.d3      = d;
        s.item    = '0;
        s.has_exp = 1'b0;
        s.exp     = '0;
        dir_steps.push_back(s);
    endfunction

    initial begin
        int unsigned   phase;
        int unsigned   target;
        nns_pkg::t_out none;
        none = '0;
        for (int i = 0; i < 4; i++)
            dim_reg[i] = 13'd1;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            pixel_store[i]  = '0;
            pixel_loaded[i] = 1'b0;
        end
        load_col_q = 0;
        out_col_q  = 0;
        out_row_q  = 0;

        // all sizes one after reset: every pull is the last pixel of an image
        dir_item(nns_pkg::KIND_LOAD, 16'h7FFF, 1'b0, none);
        dir_item(nns_pkg::KIND_PULL, 16'h0000, 1'b1, last_pixel(16'h7FFF));
        dir_item(nns_pkg::KIND_LOAD, 16'h8000, 1'b0, none);
        dir_item(nns_pkg::KIND_PULL, 16'hFFFF, 1'b1, last_pixel(16'h8000));
        dir_item(nns_pkg::KIND_LOAD, 16'hFFFF, 1'b0, none);
        dir_item(nns_pkg::KIND_PULL, 16'h5A5A, 1'b1, last_pixel(16'hFFFF));
        dir_item(nns_pkg::KIND_LOAD, 16'h0000, 1'b0, none);
        dir_item(nns_pkg::KIND_PULL, 16'h8000, 1'b1, last_pixel(16'h0000));
        // zero sizes act as one
        dir_dims(13'd0, 13'd0, 13'd0, 13'd0);
        dir_item(nns_pkg::KIND_LOAD, 16'h1234, 1'b0, none);
        dir_item(nns_pkg::KIND_PULL, 16'h0000, 1'b1, last_pixel(16'h1234));
        // upscale, then shrink the output row under the running column
        dir_dims(13'd3, 13'd2, 13'd5, 13'd3);
        dir_item(nns_pkg::KIND_LOAD, 16'h0001, 1'b0, none);
        dir_item(nns_pkg::KIND_LOAD, 16'h7FFE, 1'b0, none);
        dir_item(nns_pkg::KIND_LOAD, 16'h8001, 1'b0, none);
        dir_item(nns_pkg::KIND_PULL, 16'h0000, 1'b0, none);
        dir_item(nns_pkg::KIND_PULL, 16'hFFFF, 1'b0, none);
        dir_item(nns_pkg::KIND_PULL, 16'h0000, 1'b0, none);
        dir_dims(13'd3, 13'd2, 13'd2, 13'd3);
        dir_item(nns_pkg::KIND_PULL, 16'h0000, 1'b0, none);
        dir_item(nns_pkg::KIND_PULL, 16'h0000, 1'b0, none);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_steps[i]) begin
            if (dir_steps[i].op == STEP_DIMS) begin
                set_dims(dir_steps[i].d0, dir_steps[i].d1, dir_steps[i].d2, dir_steps[i].d3);
            end else begin
                send_item(dir_steps[i].item, dir_steps[i].has_exp, dir_steps[i].exp);
            end
        end

        gen_count = 0;
        phase     = 0;
        while (gen_count < RAND_ITEMS) begin
            set_dims(rand_width(), rand_height(), rand_width(), rand_height());
            calm = (phase == 3);
            if (phase == 5)
                hold_req++;
            target = gen_count + $urandom_range(40, 120);
            while (gen_count < target) begin
                if ($urandom_range(99) < 80) begin
                    run_row();
                end else begin
                    repeat ($urandom_range(1, 6)) send_gen(logic'($urandom_range(1)));
                end
            end
            phase++;
        end
        calm = 1'b0;

        // widths saturated from the top register value, then saturated heights
        set_dims(13'h1FFF, 13'd1, 13'h1FFF, 13'd1);
        repeat (32) send_gen(nns_pkg::KIND_LOAD);
        repeat (32) send_gen(nns_pkg::KIND_PULL);
        set_dims(13'd0, 13'h1FFF, 13'd1, 13'h1FFF);
        send_gen(nns_pkg::KIND_LOAD);
        repeat (8) send_gen(nns_pkg::KIND_PULL);

        wait_idle();
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== nearest_neighbor_image_scaler_core.f =====
hdl/nns_pkg.sv
hdl/nns_div.sv
hdl/nns_front.sv
hdl/nns_fifo.sv
hdl/nns_back.sv
hdl/nearest_neighbor_image_scaler_core.sv
bench/tb_top.sv
